### hdl/line_range_stream_filter_defines.svh
// Assertion macros shared by the line range stream filter modules.
`ifndef LINE_RANGE_STREAM_FILTER_DEFINES_SVH
`define LINE_RANGE_STREAM_FILTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LRSF_ASSERT_IMPL(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("lrsf check failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define LRSF_ASSERT_NEXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("lrsf check failed: next-cycle implication");

// The expression must never be true.
`define LRSF_ASSERT_NEVER(name, clk, rst_n, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("lrsf check failed: forbidden condition");

`endif

### hdl/lrsf_pkg.sv
// Shared types and constants of the line range stream filter.
package lrsf_pkg;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 64;
    localparam int unsigned RANGE_W     = 64;
    localparam int unsigned COUNT_W     = 3;
    localparam int unsigned NUM_RANGE_REGS = 4;
    localparam int unsigned PAD_WIDTH   = 6;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_RANGE_COUNT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RANGE_0     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_INVERT      = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_NUMBER      = 3'd6;

    // Characters.
    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;

    // What the output register is loaded with.
    typedef logic [1:0] t_emit_sel;
    localparam t_emit_sel EMIT_DIGIT = 2'd0;
    localparam t_emit_sel EMIT_COLON = 2'd1;
    localparam t_emit_sel EMIT_SPACE = 2'd2;
    localparam t_emit_sel EMIT_BYTE  = 2'd3;

    typedef struct packed {
        logic      accept;
        logic      scan;
        logic      pfx_load;
        logic      emit;
        t_emit_sel emit_sel;
        logic      finish;
    } t_cmd;

    typedef struct packed {
        logic at_start;
        logic selected;
        logic number;
        logic scan_done;
        logic k_zero;
        logic out_free;
    } t_sts;

endpackage

### hdl/lrsf_cfg.sv
// Configuration register file of the line range stream filter.
module lrsf_cfg #(
    parameter int unsigned MAX_RANGES = 4
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [lrsf_pkg::CFG_INDEX_W-1:0]       i_cfg_index,
    input  logic [lrsf_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    output logic [MAX_RANGES-1:0][lrsf_pkg::RANGE_W-1:0] o_ranges,
    output logic [$clog2(MAX_RANGES+1)-1:0]        o_range_count,
    output logic                                   o_invert,
    output logic                                   o_number
);
    import lrsf_pkg::*;

    localparam int unsigned IDX_W = $clog2(MAX_RANGES + 1);
    localparam int unsigned CMP_W = IDX_W + COUNT_W;

    logic [COUNT_W-1:0]                 r_range_count;
    logic [MAX_RANGES-1:0][RANGE_W-1:0] r_ranges;
    logic                               r_invert;
    logic                               r_number;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_count <= COUNT_W'(1);
            r_ranges      <= '0;
            r_invert      <= 1'b0;
            r_number      <= 1'b0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_RANGE_COUNT) begin
                r_range_count <= i_cfg_data[COUNT_W-1:0];
            end
            if (i_cfg_index == CFG_INVERT) begin
                r_invert <= i_cfg_data[0];
            end
            if (i_cfg_index == CFG_NUMBER) begin
                r_number <= i_cfg_data[0];
            end
            for (int j = 0; j < MAX_RANGES; j++) begin
                if (j < NUM_RANGE_REGS &&
                    i_cfg_index == CFG_INDEX_W'(int'(CFG_RANGE_0) + j)) begin
                    r_ranges[j] <= i_cfg_data[RANGE_W-1:0];
                end
            end
        end
    end

    // A count above the number of range registers uses all of them.
    always_comb begin
        if (CMP_W'(r_range_count) > CMP_W'(MAX_RANGES)) begin
            o_range_count = IDX_W'(MAX_RANGES);
        end else begin
            o_range_count = IDX_W'(r_range_count);
        end
    end

    assign o_ranges = r_ranges;
    assign o_invert = r_invert;
    assign o_number = r_number;

endmodule

### hdl/lrsf_ctrl.sv
// Controller state machine of the line range stream filter.
`include "line_range_stream_filter_defines.svh"

module lrsf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  lrsf_pkg::t_sts i_sts,
    output lrsf_pkg::t_cmd o_cmd
);
    import lrsf_pkg::*;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_CHECK     = 3'd1;
    localparam logic [2:0] S_SCAN      = 3'd2;
    localparam logic [2:0] S_DECIDE    = 3'd3;
    localparam logic [2:0] S_PFX_NUM   = 3'd4;
    localparam logic [2:0] S_PFX_COLON = 3'd5;
    localparam logic [2:0] S_PFX_SPACE = 3'd6;
    localparam logic [2:0] S_BYTE      = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.at_start) begin
                    n_state = S_SCAN;
                end else if (i_sts.selected) begin
                    n_state = S_BYTE;
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_sts.selected && i_sts.number) begin
                    o_cmd.pfx_load = 1'b1;
                    n_state        = S_PFX_NUM;
                end else if (i_sts.selected) begin
                    n_state = S_BYTE;
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_PFX_NUM: begin
                if (i_sts.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = EMIT_DIGIT;
                    if (i_sts.k_zero) begin
                        n_state = S_PFX_COLON;
                    end
                end
            end
            S_PFX_COLON: begin
                if (i_sts.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = EMIT_COLON;
                    n_state        = S_PFX_SPACE;
                end
            end
            S_PFX_SPACE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = EMIT_SPACE;
                    n_state        = S_BYTE;
                end
            end
            S_BYTE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = EMIT_BYTE;
                    o_cmd.finish   = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != S_IDLE);

    `LRSF_ASSERT_IMPL(a_emit_needs_room, i_clk, i_rst_n, o_cmd.emit, i_sts.out_free)
    `LRSF_ASSERT_NEVER(a_accept_not_finish, i_clk, i_rst_n, o_cmd.accept && o_cmd.finish)
    `LRSF_ASSERT_NEXT(a_accept_to_check, i_clk, i_rst_n, o_cmd.accept, r_state == S_CHECK)

endmodule

### hdl/lrsf_dp.sv
// Datapath of the line range stream filter: line counter, range test, prefix and output.
`include "line_range_stream_filter_defines.svh"

module lrsf_dp #(
    parameter int unsigned MAX_RANGES  = 4,
    parameter int unsigned LINE_DIGITS = 10
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  lrsf_pkg::t_cmd                         i_cmd,
    output lrsf_pkg::t_sts                         o_sts,
    input  logic [7:0]                             i_data_byte,
    input  logic                                   i_first_of_file,
    input  logic [MAX_RANGES-1:0][lrsf_pkg::RANGE_W-1:0] i_ranges,
    input  logic [$clog2(MAX_RANGES+1)-1:0]        i_range_count,
    input  logic                                   i_invert,
    input  logic                                   i_number,
    input  logic                                   i_stall,
    output logic                                   o_valid,
    output logic [7:0]                             o_out_byte,
    output logic                                   o_last_of_run
);
    import lrsf_pkg::*;

    localparam int unsigned IDX_W = $clog2(MAX_RANGES + 1);
    localparam int unsigned SEL_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int unsigned K_W   = $clog2(LINE_DIGITS);
    localparam int unsigned S_W   = $clog2(LINE_DIGITS + 1);
    localparam int unsigned BIN_W = 33;
    localparam int unsigned BCD_W = 4 * LINE_DIGITS;

    // Line state. The binary copy saturates at 2^32, which compares the same
    // way as any larger number against the 32-bit range bounds.
    logic [LINE_DIGITS-1:0][3:0] r_bcd;
    logic [LINE_DIGITS-1:0][3:0] n_bcd;
    logic [BIN_W-1:0]            r_line_bin;
    logic [BIN_W-1:0]            n_line_bin;
    logic [IDX_W-1:0]            r_range_index;
    logic                        r_at_start;
    logic                        r_selected;

    logic [7:0]     r_byte;
    logic [K_W-1:0] r_k;
    logic [S_W-1:0] r_sig;

    logic           r_out_valid;
    logic [7:0]     r_out_byte;
    logic           r_out_last;

    logic                scan_valid;
    logic [RANGE_W-1:0]  rng;
    logic [31:0]         lo;
    logic [31:0]         hi;
    logic                below_start;
    logic                within_end;
    logic                scan_done;
    logic                want;
    logic                all_nines;
    logic                carry;
    logic [S_W-1:0]      sig;
    logic [S_W-1:0]      width;
    logic [3:0]          digit;
    logic [7:0]          emit_char;
    logic                out_free;

    // Test of one range per cycle.
    always_comb begin
        scan_valid  = r_range_index < i_range_count;
        rng         = i_ranges[r_range_index[SEL_W-1:0]];
        lo          = rng[63:32];
        hi          = rng[31:0];
        below_start = (lo != 32'd0) && (r_line_bin < {1'b0, lo});
        within_end  = (hi == 32'd0) || (r_line_bin <= {1'b0, hi});
        scan_done   = !scan_valid || below_start || within_end;
        want        = scan_valid && !below_start;
    end

    // Decimal increment with saturation at all nines.
    always_comb begin
        all_nines = 1'b1;
        for (int i = 0; i < LINE_DIGITS; i++) begin
            all_nines = all_nines && (r_bcd[i] == 4'd9);
        end
        carry = !all_nines;
        n_bcd = r_bcd;
        for (int i = 0; i < LINE_DIGITS; i++) begin
            if (carry) begin
                n_bcd[i] = (r_bcd[i] == 4'd9) ? 4'd0 : r_bcd[i] + 4'd1;
            end
            carry = carry && (r_bcd[i] == 4'd9);
        end
        if (!all_nines && !r_line_bin[BIN_W-1]) begin
            n_line_bin = r_line_bin + BIN_W'(1);
        end else begin
            n_line_bin = r_line_bin;
        end
    end

    // Number of significant digits and the printed field width.
    always_comb begin
        sig = S_W'(1);
        for (int i = 1; i < LINE_DIGITS; i++) begin
            if (r_bcd[i] != 4'd0) begin
                sig = S_W'(i + 1);
            end
        end
        width = (sig > S_W'(PAD_WIDTH)) ? sig : S_W'(PAD_WIDTH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bcd         <= BCD_W'(1);
            r_line_bin    <= BIN_W'(1);
            r_range_index <= '0;
            r_at_start    <= 1'b1;
            r_selected    <= 1'b0;
        end else begin
            if (i_cmd.accept && i_first_of_file) begin
                r_bcd         <= BCD_W'(1);
                r_line_bin    <= BIN_W'(1);
                r_range_index <= '0;
                r_at_start    <= 1'b1;
            end
            if (i_cmd.scan) begin
                if (scan_done) begin
                    r_selected <= want ^ i_invert;
                    r_at_start <= 1'b0;
                end else begin
                    r_range_index <= r_range_index + IDX_W'(1);
                end
            end
            if (i_cmd.finish && (r_byte == CHAR_NL)) begin
                r_at_start <= 1'b1;
                r_bcd      <= n_bcd;
                r_line_bin <= n_line_bin;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_byte <= i_data_byte;
        end
        if (i_cmd.pfx_load) begin
            r_k   <= K_W'(width - S_W'(1));
            r_sig <= sig;
        end else if (i_cmd.emit && (i_cmd.emit_sel == EMIT_DIGIT)) begin
            r_k <= r_k - K_W'(1);
        end
    end

    always_comb begin
        digit = r_bcd[r_k];
        unique case (i_cmd.emit_sel)
            EMIT_DIGIT: begin
                emit_char = (S_W'(r_k) >= r_sig) ? CHAR_SPACE : (CHAR_ZERO + {4'h0, digit});
            end
            EMIT_COLON: emit_char = CHAR_COLON;
            EMIT_SPACE: emit_char = CHAR_SPACE;
            EMIT_BYTE:  emit_char = r_byte;
        endcase
    end

    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_byte <= emit_char;
            r_out_last <= (i_cmd.emit_sel == EMIT_BYTE);
        end
    end

    always_comb begin
        o_sts.at_start  = r_at_start;
        o_sts.selected  = r_selected;
        o_sts.number    = i_number;
        o_sts.scan_done = scan_done;
        o_sts.k_zero    = (r_k == '0);
        o_sts.out_free  = out_free;
    end

    assign o_valid       = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_last_of_run = r_out_last;

    `LRSF_ASSERT_NEXT(a_emit_fills_output, i_clk, i_rst_n, i_cmd.emit, r_out_valid)
    `LRSF_ASSERT_NEXT(a_byte_ends_run, i_clk, i_rst_n, i_cmd.emit && (i_cmd.emit_sel == EMIT_BYTE), r_out_last)
    `LRSF_ASSERT_NEXT(a_newline_starts_line, i_clk, i_rst_n, i_cmd.finish && (r_byte == CHAR_NL), r_at_start)

endmodule

### hdl/line_range_stream_filter.sv
// Top level of the line range stream filter.
//
// The filter takes a text stream one byte per input beat and passes on only
// the bytes of lines whose numbers fall in the configured ranges (or outside
// them when invert_selection is set). A line ends with a newline byte, which
// belongs to the line it ends. A beat with first_of_file set restarts the line
// count at 1 and the range scan at the first range before that byte is
// handled. Each range register holds its start line in bits 63..32 and its end
// line in bits 31..0; a start of 0 is open toward line 1 and an end of 0 is
// open to the end of the file. Ranges are expected sorted and disjoint; the
// scan only moves forward through them within a file. With number_lines set,
// every passed line is preceded by its number, right-aligned in six columns
// with spaces (wider for longer numbers), followed by a colon and a space.
// The line number stops counting at 10^LINE_DIGITS - 1. The last output beat
// caused by an input byte carries last_of_run; an input byte that is dropped
// produces no output beat at all.
//
// Timing: the block works on one input byte at a time, sequenced by its
// controller. A byte in the middle of a line is checked and then dropped, or
// checked and passed to the output. The first byte of a line additionally
// tests the ranges one per cycle and then decides, and with numbering on it
// emits max(6, digits) + 2 prefix beats, one per cycle while the output is
// free. Output beats are held in a single output register, so a stall
// on the output side holds the controller only when it has a beat to place.
// Configuration registers may be written only while no byte is in flight.
module line_range_stream_filter #(
    parameter int unsigned MAX_RANGES  = 4,
    parameter int unsigned LINE_DIGITS = 10
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,

    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [7:0]                       i_data_byte,
    input  logic                             i_first_of_file,

    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [7:0]                       o_out_byte,
    output logic                             o_last_of_run,

    input  logic                             i_cfg_we,
    input  logic [lrsf_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [lrsf_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import lrsf_pkg::*;

    localparam int unsigned IDX_W = $clog2(MAX_RANGES + 1);

    logic [MAX_RANGES-1:0][RANGE_W-1:0] ranges;
    logic [IDX_W-1:0]                   range_count;
    logic                               invert;
    logic                               number;
    t_cmd                               cmd;
    t_sts                               sts;

    // Configuration registers; the range count is already capped here.
    lrsf_cfg #(
        .MAX_RANGES (MAX_RANGES)
    ) u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_ranges      (ranges),
        .o_range_count (range_count),
        .o_invert      (invert),
        .o_number      (number)
    );

    // The controller owns the input handshake and sequences each byte.
    lrsf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // The datapath holds the line state and the output register.
    lrsf_dp #(
        .MAX_RANGES  (MAX_RANGES),
        .LINE_DIGITS (LINE_DIGITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_data_byte     (i_data_byte),
        .i_first_of_file (i_first_of_file),
        .i_ranges        (ranges),
        .i_range_count   (range_count),
        .i_invert        (invert),
        .i_number        (number),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_out_byte      (o_out_byte),
        .o_last_of_run   (o_last_of_run)
    );

endmodule
